/* src/unique_key_fifo_unit_assert.svh */
// ----------------------------------------------------------------------------
// unique_key_fifo_unit assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_KEY_FIFO_UNIT_ASSERT_SVH
`define UNIQUE_KEY_FIFO_UNIT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define UKF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define UKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ukf_pkg.sv */
// ----------------------------------------------------------------------------
// ukf_pkg
// Shared constants, codes, command/status structs and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ukf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;

  localparam int KEY_W   = 32;
  localparam int HPORT_W = 16;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  // stored handle width: the port width caps it
  localparam int SH_W    = (HANDLE_BITS < HPORT_W) ? HANDLE_BITS : HPORT_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic    latch_in;
    logic    scan_start;
    logic    scan_run;
    logic    set_status;
    status_t status_code;
    logic    load_hit;
    logic    write_en;
    logic    pop;
    logic    head_ld;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    occ_zero;
    logic    full;
    logic    hit;
    logic    scan_done;
  } dp_stat_t;

  // slot of the entry 'off' places behind the head, wrapping at QUEUE_DEPTH
  function automatic logic [PTR_W-1:0] slot_of(logic [PTR_W-1:0] head,
                                               logic [COUNT_W-1:0] off);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W + 1)'(head) + (COUNT_W + 1)'(off);
    if (sum >= (COUNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (COUNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [HPORT_W-1:0] ext_handle(logic [SH_W-1:0] h);
    logic [HPORT_W-1:0] r;
    r = '0;
    r[SH_W-1:0] = h;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/ukf_ram.sv */
// ----------------------------------------------------------------------------
// ukf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ukf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/ukf_ctrl.sv */
// ----------------------------------------------------------------------------
// ukf_ctrl
// Sequencer: decodes the request, steps the key scan, drives the result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ukf_ctrl
  import ukf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_WRITE    = 7'b0001000,
    S_POP      = 7'b0010000,
    S_HEAD_LD  = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.occ_zero) begin
              state_next = S_WRITE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          OP_REMOVE: begin
            if (stat.occ_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_FINISH;
            end else begin
              state_next = S_POP;
            end
          end
          OP_SEARCH: begin
            if (stat.occ_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        priority if (stat.hit) begin
          if (stat.op == OP_INSERT) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DUP;
          end else begin
            cmd.load_hit = 1'b1;
          end
          state_next = S_FINISH;
        end else if (stat.scan_done) begin
          if (stat.op == OP_INSERT) begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_next      = S_FINISH;
            end else begin
              state_next = S_WRITE;
            end
          end else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOTFOUND;
            state_next      = S_FINISH;
          end
        end
      end
      S_WRITE: begin
        cmd.write_en = 1'b1;
        state_next   = S_FINISH;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_HEAD_LD;
      end
      S_HEAD_LD: begin
        cmd.head_ld = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/ukf_dp.sv */
// ----------------------------------------------------------------------------
// ukf_dp
// Datapath: key/handle stores, head pointer, occupancy, scan and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ukf_dp
  import ukf_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ctl_cmd_t                   cmd,
  output dp_stat_t                        stat,
  input  wire logic [1:0]                 opcode,
  input  wire logic signed [KEY_W-1:0]    key,
  input  wire logic [HPORT_W-1:0]         item_handle,
  output logic [2:0]                      status,
  output logic [HPORT_W-1:0]              result_handle,
  output logic [COUNT_W-1:0]              entry_count,
  output logic                            queue_empty,
  output logic [HPORT_W-1:0]              head_handle
);

  // latched request
  opcode_t                  op_r;
  logic signed [KEY_W-1:0]  key_r;
  logic [SH_W-1:0]          hdl_r;

  // queue state
  logic [PTR_W-1:0]         head_ptr;
  logic [COUNT_W-1:0]       occ;
  logic [SH_W-1:0]          head_reg;

  // scan
  logic [COUNT_W-1:0]       idx;
  logic                     cmp_valid;
  logic                     issue;

  // pending result and output slot
  status_t                  status_r;
  logic [HPORT_W-1:0]       result_r;
  status_t                  out_status;
  logic [HPORT_W-1:0]       out_result;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_empty;
  logic [HPORT_W-1:0]       out_head;

  // store ports
  logic [PTR_W-1:0]         rd_addr;
  logic [PTR_W-1:0]         wr_addr;
  logic [KEY_W-1:0]         key_rdata;
  logic [SH_W-1:0]          hdl_rdata;

  assign issue   = cmd.scan_run && (idx < occ);
  assign rd_addr = cmd.pop ? slot_of(head_ptr, COUNT_W'(1)) : slot_of(head_ptr, idx);
  assign wr_addr = slot_of(head_ptr, occ);

  ukf_ram #(.WIDTH(KEY_W), .DEPTH(QUEUE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (cmd.write_en),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  ukf_ram #(.WIDTH(SH_W), .DEPTH(QUEUE_DEPTH)) u_hdl_ram (
    .clk   (clk),
    .we    (cmd.write_en),
    .waddr (wr_addr),
    .wdata (hdl_r),
    .raddr (rd_addr),
    .rdata (hdl_rdata)
  );

  always_comb begin
    stat.op        = op_r;
    stat.occ_zero  = (occ == '0);
    stat.full      = (occ == COUNT_W'(QUEUE_DEPTH));
    stat.hit       = cmp_valid && (key_rdata == key_r);
    stat.scan_done = (idx == occ) && !cmp_valid;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr  <= '0;
      occ       <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        idx       <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_valid <= issue;
        if (issue) begin
          idx <= idx + COUNT_W'(1);
        end
      end
      if (cmd.write_en) begin
        occ <= occ + COUNT_W'(1);
      end else if (cmd.pop) begin
        occ      <= occ - COUNT_W'(1);
        head_ptr <= slot_of(head_ptr, COUNT_W'(1));
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r     <= opcode_t'(opcode);
      key_r    <= key;
      hdl_r    <= item_handle[SH_W-1:0];
      status_r <= ST_OK;
      result_r <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.load_hit) begin
      result_r <= ext_handle(hdl_rdata);
    end
    if (cmd.pop) begin
      result_r <= ext_handle(head_reg);
    end
    // first entry becomes the head
    if (cmd.write_en && (occ == '0)) begin
      head_reg <= hdl_r;
    end
    if (cmd.head_ld) begin
      head_reg <= hdl_rdata;
    end
    if (cmd.out_load) begin
      out_status <= status_r;
      out_result <= result_r;
      out_count  <= occ;
      out_empty  <= (occ == '0);
      out_head   <= (occ == '0) ? '0 : ext_handle(head_reg);
    end
  end

  assign status        = out_status;
  assign result_handle = out_result;
  assign entry_count   = out_count;
  assign queue_empty   = out_empty;
  assign head_handle   = out_head;

endmodule

`default_nettype wire

/* src/unique_key_fifo_unit.sv */
// ----------------------------------------------------------------------------
// unique_key_fifo_unit
// Bounded FIFO of (key, handle) records with duplicate-key check on insert,
// head removal and search by key.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | opcode, key, item_handle
//  out      | out_valid / out_stall| status, result_handle, entry_count,
//           |                      | queue_empty, head_handle
//
//  One request is in work at a time; in_stall is low only while the sequencer
//  is idle. An ignored opcode, or a remove or search on an empty queue, goes
//  straight to the finish; a remove pops the head and reloads it; insert and
//  search on a non-empty queue run the key scan, which reads one stored key
//  per cycle through the key RAM's single read port.
//  The result sits in an output register, so the next request is taken while
//  it waits; a held result only delays the finish of the following request.
//  rst is synchronous and active high; it empties the queue. The key and
//  handle stores are not cleared: only the contents of occupied slots reach the outputs.
//
`default_nettype none

module unique_key_fifo_unit
  import ukf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               opcode,
  input  wire logic signed [KEY_W-1:0]  key,
  input  wire logic [HPORT_W-1:0]       item_handle,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    status,
  output logic [HPORT_W-1:0]            result_handle,
  output logic [COUNT_W-1:0]            entry_count,
  output logic                          queue_empty,
  output logic [HPORT_W-1:0]            head_handle
);

`include "unique_key_fifo_unit_assert.svh"

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: decode, scan stepping, result slot handshake
  ukf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stores, pointers, comparator and output registers
  ukf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (opcode),
    .key           (key),
    .item_handle   (item_handle),
    .status        (status),
    .result_handle (result_handle),
    .entry_count   (entry_count),
    .queue_empty   (queue_empty),
    .head_handle   (head_handle)
  );

  // an insert is only written while there is room
  `UKF_ASSERT_IMPL(a_write_room, cmd.write_en, !stat.full, "insert written into full queue")
  // a remove only pops a non-empty queue
  `UKF_ASSERT_IMPL(a_pop_nonempty, cmd.pop, !stat.occ_zero, "pop of empty queue")
  // empty flag agrees with the count in every shown result
  `UKF_ASSERT_IMPL(a_empty_flag, out_valid, queue_empty == (entry_count == '0), "empty flag mismatch")
  // failed requests carry no handle
  `UKF_ASSERT_IMPL(a_fail_zero, out_valid && (status != ST_OK), result_handle == '0, "handle on failure")

endmodule

`default_nettype wire
